// ===== hw/rtl/time_of_day_clock_core_defines.svh =====
// assertion macros shared by the time-of-day clock checkers
`ifndef TIME_OF_DAY_CLOCK_CORE_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define TOD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define TOD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also runs through reset
`define TOD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tod_pkg.sv =====
// types and constants of the time-of-day clock
package tod_pkg;

   // widths of the clock fields
   localparam int unsigned HourWidth   = 5;
   localparam int unsigned MinuteWidth = 6;
   localparam int unsigned SecondWidth = 6;
   localparam int unsigned DaySecWidth = 17;
   localparam int unsigned MsWidth     = 16;
   localparam int unsigned AccWidth    = 17;
   localparam int unsigned OpWidth     = 3;

   // field limits, reset threshold and seconds per hour and per minute
   localparam logic [HourWidth-1:0]   LastHour   = 5'd23;
   localparam logic [MinuteWidth-1:0] LastMinute = 6'd59;
   localparam logic [SecondWidth-1:0] LastSecond = 6'd59;
   localparam logic [MsWidth-1:0]     MsReset    = 16'd1000;
   localparam logic [DaySecWidth-1:0] SecPerHour = 17'd3600;
   localparam logic [DaySecWidth-1:0] SecPerMin  = 17'd60;

   // command codes
   typedef enum logic [OpWidth-1:0] {
      OP_TICK      = 3'd0,
      OP_HOUR_UP   = 3'd1,
      OP_HOUR_DOWN = 3'd2,
      OP_MIN_UP    = 3'd3,
      OP_MIN_DOWN  = 3'd4
   } opcode_type;

   // current time of day
   typedef struct packed {
      logic [HourWidth-1:0]   hours;
      logic [MinuteWidth-1:0] minutes;
      logic [SecondWidth-1:0] seconds;
   } time_type;

endpackage

// ===== hw/rtl/tod_calc.sv =====
// next-state logic of the clock: tick, set commands and day-second total
module tod_calc (
   input  logic [tod_pkg::OpWidth-1:0]     opcode,
   input  logic [tod_pkg::MsWidth-1:0]     elapsed_ms,
   input  logic [tod_pkg::MsWidth-1:0]     ms_per_second,
   input  logic [tod_pkg::AccWidth-1:0]    acc_cur,
   input  tod_pkg::time_type               time_cur,
   output logic [tod_pkg::AccWidth-1:0]    acc_next,
   output tod_pkg::time_type               time_next,
   output logic [tod_pkg::DaySecWidth-1:0] day_seconds
);

   logic [tod_pkg::AccWidth-1:0] acc_sum;
   logic                         sec_step;
   logic                         sec_wrap;
   logic                         min_wrap;

   // accumulate elapsed time; a full second clears the remainder
   assign acc_sum  = acc_cur + {1'b0, elapsed_ms};
   assign sec_step = (acc_sum >= {1'b0, ms_per_second});
   assign sec_wrap = (time_cur.seconds == tod_pkg::LastSecond);
   assign min_wrap = (time_cur.minutes == tod_pkg::LastMinute);

   // command decode
   always_comb begin
      acc_next  = acc_cur;
      time_next = time_cur;
      case (opcode)
         tod_pkg::OP_TICK: begin
            if (sec_step) begin
               acc_next = '0;
               if (sec_wrap) begin
                  time_next.seconds = '0;
                  if (min_wrap) begin
                     time_next.minutes = '0;
                     if (time_cur.hours >= tod_pkg::LastHour) begin
                        time_next.hours = '0;
                     end else begin
                        time_next.hours = time_cur.hours + 1'b1;
                     end
                  end else begin
                     time_next.minutes = time_cur.minutes + 1'b1;
                  end
               end else begin
                  time_next.seconds = time_cur.seconds + 1'b1;
               end
            end else begin
               acc_next = acc_sum;
            end
         end
         tod_pkg::OP_HOUR_UP: begin
            time_next.hours = (time_cur.hours >= tod_pkg::LastHour) ? '0
                                                                  : time_cur.hours + 1'b1;
         end
         tod_pkg::OP_HOUR_DOWN: begin
            time_next.hours = (time_cur.hours == '0) ? tod_pkg::LastHour
                                                     : time_cur.hours - 1'b1;
         end
         tod_pkg::OP_MIN_UP: begin
            time_next.minutes = (time_cur.minutes >= tod_pkg::LastMinute) ? '0
                                                                        : time_cur.minutes + 1'b1;
         end
         tod_pkg::OP_MIN_DOWN: begin
            time_next.minutes = (time_cur.minutes == '0) ? tod_pkg::LastMinute
                                                         : time_cur.minutes - 1'b1;
         end
         default: begin
            acc_next  = acc_cur;
            time_next = time_cur;
         end
      endcase
   end

   // seconds since midnight of the updated time
   assign day_seconds =
      ({12'd0, time_next.hours} * tod_pkg::SecPerHour) +
      ({11'd0, time_next.minutes} * tod_pkg::SecPerMin) +
      {11'd0, time_next.seconds};

endmodule

// ===== hw/rtl/time_of_day_clock_core.sv =====
// top level of the time-of-day clock
//
// Request channel (req_): one command per transfer. req_tuser carries the
// opcode (tick, hour up/down, minute up/down); req_tdata carries the elapsed
// milliseconds, used by a tick only. Response channel (rsp_): exactly one
// transfer per command, holding hours, minutes, seconds and seconds of the
// day after the command has taken effect, in command order.
// csr_wr_en / csr_wr_data set the milliseconds per second; write it only
// while no command is in flight.
// A request passes from the input register through the update logic, which
// feeds the state and the response register.
// Throughput is one command per cycle while rsp_tready stays high; the time
// registers take one update per accepted command.
// Reset clears the time and the millisecond accumulator, sets the threshold
// to 1000 and empties both pipeline registers.
// When the receiver holds rsp_tready low the response stays put, the input
// register still takes one more command, and req_tready then drops until
// the response drains.
module time_of_day_clock_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] elapsed_ms, [23:16] zero
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] hours, [10:5] minutes,
                                    // [16:11] seconds, [33:17] day_seconds,
                                    // [39:34] zero
   // threshold register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                                in_valid_ff, in_valid_in;
   logic [tod_pkg::OpWidth-1:0]         in_op_ff, in_op_in;
   logic [tod_pkg::MsWidth-1:0]         in_ms_ff, in_ms_in;
   logic                                out_valid_ff, out_valid_in;
   tod_pkg::time_type                   out_time_ff, out_time_in;
   logic [tod_pkg::DaySecWidth-1:0]     out_dsec_ff, out_dsec_in;
   logic [tod_pkg::MsWidth-1:0]         thresh_ff, thresh_in;
   logic [tod_pkg::AccWidth-1:0]        acc_ff, acc_in;
   tod_pkg::time_type                   time_ff, time_in;
   logic [tod_pkg::AccWidth-1:0]        acc_next;
   tod_pkg::time_type                   time_next;
   logic [tod_pkg::DaySecWidth-1:0]     dsec_next;
   logic                                advance;

   // pipeline flow control
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // update logic
   tod_calc u_calc (
      .opcode        (in_op_ff),
      .elapsed_ms    (in_ms_ff),
      .ms_per_second (thresh_ff),
      .acc_cur       (acc_ff),
      .time_cur      (time_ff),
      .acc_next      (acc_next),
      .time_next     (time_next),
      .day_seconds   (dsec_next)
   );

   // next values of all registers
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_ms_in     = in_ms_ff;
      out_valid_in = out_valid_ff;
      out_time_in  = out_time_ff;
      out_dsec_in  = out_dsec_ff;
      thresh_in    = thresh_ff;
      acc_in       = acc_ff;
      time_in      = time_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_op_in    = req_tuser;
         in_ms_in    = req_tdata[tod_pkg::MsWidth-1:0];
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_time_in  = time_next;
         out_dsec_in  = dsec_next;
         acc_in       = acc_next;
         time_in      = time_next;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         thresh_in = csr_wr_data;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         thresh_ff    <= tod_pkg::MsReset;
         acc_ff       <= '0;
         time_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         thresh_ff    <= thresh_in;
         acc_ff       <= acc_in;
         time_ff      <= time_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_op_ff    <= in_op_in;
      in_ms_ff    <= in_ms_in;
      out_time_ff <= out_time_in;
      out_dsec_ff <= out_dsec_in;
   end

   // response packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_dsec_ff, out_time_ff.seconds,
                        out_time_ff.minutes, out_time_ff.hours};

endmodule

// ===== hw/rtl/tod_checker.sv =====
// port-level checks of the time-of-day clock, bound to the top level
`include "time_of_day_clock_core_defines.svh"

module tod_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   logic [4:0]  chk_hours;
   logic [5:0]  chk_minutes;
   logic [5:0]  chk_seconds;
   logic [16:0] chk_dsec;
   logic [16:0] chk_total;

   // unpack the response fields
   assign chk_hours   = rsp_tdata[4:0];
   assign chk_minutes = rsp_tdata[10:5];
   assign chk_seconds = rsp_tdata[16:11];
   assign chk_dsec    = rsp_tdata[33:17];
   assign chk_total   = ({12'd0, chk_hours} * 17'd3600) +
                        ({11'd0, chk_minutes} * 17'd60) + {11'd0, chk_seconds};

   // time fields stay in range
   `TOD_ASSERT_NOW(a_fields_in_range, clock, reset, rsp_tvalid, (chk_hours <= 5'd23) && (chk_minutes <= 6'd59) && (chk_seconds <= 6'd59), "response time field out of range")

   // day-second total agrees with the time fields
   `TOD_ASSERT_NOW(a_day_seconds_match, clock, reset, rsp_tvalid, chk_dsec == chk_total, "day_seconds does not match hours, minutes and seconds")

   // no response right after reset
   `TOD_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "response valid right after reset")

   // a stalled response holds
   `TOD_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

endmodule

bind time_of_day_clock_core tod_checker u_tod_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/time_of_day_clock_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the time-of-day clock core
module time_of_day_clock_core_tb;

   // opcodes the block leaves without effect
   localparam logic [tod_pkg::OpWidth-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [tod_pkg::OpWidth-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [tod_pkg::OpWidth-1:0] OP_SPARE_7 = 3'd7;

   localparam int unsigned PhaseCount    = 9;
   localparam int unsigned ItemsPerPhase = 160;
   localparam int unsigned SettleCycles  = 4;
   localparam int unsigned HalfDay       = 12;
   localparam int unsigned HalfHour      = 30;

   // threshold per phase; phases flagged in the mask draw a random one
   localparam logic [tod_pkg::MsWidth-1:0] PhaseThreshold [PhaseCount] = '{
      tod_pkg::MsReset, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd500, 16'hFFFF, 16'd1, 16'd0
   };
   localparam logic [PhaseCount-1:0] RandomThreshold = 9'b1_0001_0000;

   // one clock reading as carried by a response
   typedef struct packed {
      logic [tod_pkg::HourWidth-1:0]   hours;
      logic [tod_pkg::MinuteWidth-1:0] minutes;
      logic [tod_pkg::SecondWidth-1:0] seconds;
      logic [tod_pkg::DaySecWidth-1:0] day_seconds;
   } reading_type;

   typedef struct packed {
      logic [tod_pkg::OpWidth-1:0] op;
      logic [tod_pkg::MsWidth-1:0] ms;
      logic                        has_fixed;
      reading_type                 fixed;
   } command_row_type;

   // directed commands, starting from reset with a threshold of 1000
   localparam command_row_type DirectedRows [21] = '{
      '{tod_pkg::OP_TICK,      16'd0,     1'b1, '{5'd0,  6'd0,  6'd0, 17'd0}},
      '{tod_pkg::OP_TICK,      16'd999,   1'b1, '{5'd0,  6'd0,  6'd0, 17'd0}},
      '{tod_pkg::OP_TICK,      16'd1,     1'b1, '{5'd0,  6'd0,  6'd1, 17'd1}},
      '{tod_pkg::OP_HOUR_DOWN, 16'd0,     1'b1, '{5'd23, 6'd0,  6'd1, 17'd82801}},
      '{tod_pkg::OP_MIN_DOWN,  16'd0,     1'b1, '{5'd23, 6'd59, 6'd1, 17'd86341}},
      '{tod_pkg::OP_HOUR_UP,   16'd0,     1'b1, '{5'd0,  6'd59, 6'd1, 17'd3541}},
      '{tod_pkg::OP_MIN_UP,    16'd0,     1'b1, '{5'd0,  6'd0,  6'd1, 17'd1}},
      '{tod_pkg::OP_HOUR_UP,   16'hFFFF,  1'b1, '{5'd1,  6'd0,  6'd1, 17'd3601}},
      '{tod_pkg::OP_MIN_DOWN,  16'hFFFF,  1'b0, '0},
      '{tod_pkg::OP_TICK,      16'hFFFF,  1'b1, '{5'd1,  6'd59, 6'd2, 17'd7142}},
      '{OP_SPARE_5,            16'hFFFF,  1'b1, '{5'd1,  6'd59, 6'd2, 17'd7142}},
      '{OP_SPARE_6,            16'hAAAA,  1'b0, '0},
      '{OP_SPARE_7,            16'h5555,  1'b0, '0},
      '{tod_pkg::OP_TICK,      16'h5555,  1'b0, '0},
      '{tod_pkg::OP_TICK,      16'hAAAA,  1'b0, '0},
      '{tod_pkg::OP_TICK,      16'd500,   1'b0, '0},
      '{tod_pkg::OP_HOUR_DOWN, 16'h5555,  1'b0, '0},
      '{tod_pkg::OP_HOUR_DOWN, 16'hAAAA,  1'b0, '0},
      '{tod_pkg::OP_TICK,      16'd499,   1'b0, '0},
      '{tod_pkg::OP_MIN_UP,    16'd0,     1'b0, '0},
      '{tod_pkg::OP_MIN_UP,    16'd0,     1'b0, '0}
   };

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata   = '0;
   logic [2:0]        req_tuser   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [39:0]       rsp_tdata;
   logic              csr_wr_en   = 1'b0;
   logic [15:0]       csr_wr_data = '0;

   // predicted clock state
   logic [tod_pkg::AccWidth-1:0]    acc_ms;
   logic [tod_pkg::SecondWidth-1:0] sec_now;
   logic [tod_pkg::MinuteWidth-1:0] min_now;
   logic [tod_pkg::HourWidth-1:0]   hour_now;
   logic [tod_pkg::MsWidth-1:0]     ms_threshold;

   reading_type pending_readings [$];
   reading_type oldest_reading;
   int unsigned mismatch_count = 0;
   int unsigned items_sent     = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;

   time_of_day_clock_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // applies one command to the predicted clock and returns the new reading
   function automatic reading_type advance_clock(input logic [tod_pkg::OpWidth-1:0] op,
                                                 input logic [tod_pkg::MsWidth-1:0] ms);
      logic [tod_pkg::AccWidth:0] sum;
      reading_type                now_reading;
      case (op)
         tod_pkg::OP_TICK: begin
            sum = {1'b0, acc_ms} + ms;
            acc_ms = sum[tod_pkg::AccWidth-1:0];
            if (acc_ms >= {1'b0, ms_threshold}) begin
               acc_ms = '0;
               // seconds carry into minutes, minutes into hours
               if (sec_now == tod_pkg::LastSecond) begin
                  sec_now = '0;
                  if (min_now == tod_pkg::LastMinute) begin
                     min_now = '0;
                     hour_now = (hour_now >= tod_pkg::LastHour) ? '0 : hour_now + 1'b1;
                  end else begin
                     min_now = min_now + 1'b1;
                  end
               end else begin
                  sec_now = sec_now + 1'b1;
               end
            end
         end
         tod_pkg::OP_HOUR_UP:
            hour_now = (hour_now >= tod_pkg::LastHour) ? '0 : hour_now + 1'b1;
         tod_pkg::OP_HOUR_DOWN:
            hour_now = (hour_now == '0) ? tod_pkg::LastHour : hour_now - 1'b1;
         tod_pkg::OP_MIN_UP:
            min_now = (min_now >= tod_pkg::LastMinute) ? '0 : min_now + 1'b1;
         tod_pkg::OP_MIN_DOWN:
            min_now = (min_now == '0) ? tod_pkg::LastMinute : min_now - 1'b1;
         default: ;
      endcase
      now_reading.hours       = hour_now;
      now_reading.minutes     = min_now;
      now_reading.seconds     = sec_now;
      now_reading.day_seconds = hour_now * tod_pkg::SecPerHour +
                                min_now * tod_pkg::SecPerMin + sec_now;
      return now_reading;
   endfunction

   function automatic void check_field(input string field_name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, field_name, want, got);
         mismatch_count++;
      end
   endfunction

   // one command transfer; the reading is predicted once it is accepted
   task automatic issue_command(input logic [tod_pkg::OpWidth-1:0] op,
                                input logic [tod_pkg::MsWidth-1:0] ms,
                                input logic has_fixed, input reading_type fixed);
      reading_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {8'h00, ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_clock(op, ms);
      pending_readings.push_back(has_fixed ? fixed : predicted);
      items_sent++;
   endtask

   // hold off the sender until every pending reading has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // response side: random stalls and field-by-field compare
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t ns: response expected none, actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            oldest_reading = pending_readings.pop_front();
            check_field("hours", oldest_reading.hours, rsp_tdata[4:0]);
            check_field("minutes", oldest_reading.minutes, rsp_tdata[10:5]);
            check_field("seconds", oldest_reading.seconds, rsp_tdata[16:11]);
            check_field("day_seconds", oldest_reading.day_seconds, rsp_tdata[33:17]);
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // stimulus
   initial begin
      int unsigned                  roll;
      int unsigned                  phase_start;
      logic [tod_pkg::OpWidth-1:0]  op;
      logic [tod_pkg::MsWidth-1:0]  ms;
      logic [tod_pkg::MsWidth-1:0]  next_threshold;
      acc_ms       = '0;
      sec_now      = '0;
      min_now      = '0;
      hour_now     = '0;
      ms_threshold = tod_pkg::MsReset;
      send_idle_pct = 17;
      recv_idle_pct = 48;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DirectedRows[i])
         issue_command(DirectedRows[i].op, DirectedRows[i].ms, DirectedRows[i].has_fixed,
                       DirectedRows[i].fixed);

      for (int phase = 0; phase < PhaseCount; phase++) begin
         // idle pattern: sender light then heavy, receiver the reverse, then none
         case (phase / 3)
            0:       begin send_idle_pct = 17; recv_idle_pct = 48; end
            1:       begin send_idle_pct = 48; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase

         // new threshold while nothing is in flight
         if (phase != 0) begin
            next_threshold = RandomThreshold[phase] ?
                             tod_pkg::MsWidth'($urandom_range(65535, 1)) :
                             PhaseThreshold[phase];
            csr_wr_en   <= 1'b1;
            csr_wr_data <= next_threshold;
            @(posedge clock);
            csr_wr_en   <= 1'b0;
            ms_threshold = next_threshold;
         end

         phase_start = items_sent;
         while (items_sent - phase_start < ItemsPerPhase) begin
            roll = $urandom_range(999);
            if (roll < 10) begin
               // set the clock to 23:59, then tick through midnight
               while (hour_now != tod_pkg::LastHour)
                  issue_command((hour_now >= HalfDay) ? tod_pkg::OP_HOUR_UP
                                                      : tod_pkg::OP_HOUR_DOWN,
                                tod_pkg::MsWidth'($urandom), 1'b0, '0);
               while (min_now != tod_pkg::LastMinute)
                  issue_command((min_now >= HalfHour) ? tod_pkg::OP_MIN_UP
                                                      : tod_pkg::OP_MIN_DOWN,
                                tod_pkg::MsWidth'($urandom), 1'b0, '0);
               do
                  issue_command(tod_pkg::OP_TICK, '1, 1'b0, '0);
               while (sec_now != '0);
            end else if (roll < 17) begin
               drain_responses();
            end else begin
               roll = $urandom_range(99);
               if (roll < 60)
                  op = tod_pkg::OP_TICK;
               else if (roll < 90)
                  op = tod_pkg::OpWidth'($urandom_range(tod_pkg::OP_MIN_DOWN,
                                                        tod_pkg::OP_HOUR_UP));
               else
                  op = tod_pkg::OpWidth'($urandom_range(OP_SPARE_7, OP_SPARE_5));
               // elapsed time: anywhere, up to the threshold, or exactly reaching it
               roll = $urandom_range(99);
               if (roll < 40)
                  ms = tod_pkg::MsWidth'($urandom);
               else if (roll < 80)
                  ms = tod_pkg::MsWidth'($urandom_range(ms_threshold));
               else if (acc_ms > {1'b0, ms_threshold})
                  ms = '0;
               else
                  ms = tod_pkg::MsWidth'({1'b0, ms_threshold} - acc_ms);
               issue_command(op, ms, 1'b0, '0);
            end
         end
         drain_responses();
      end

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
